>>> rtl/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg: shared types and constants for the closest segment unit
// Widths of the coordinate, fraction and accumulator paths and the
// sequencer state type.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int COORD_W      = 16;
  localparam int FRAC_W       = 16;
  localparam int MAX_SEGMENTS = 65536;
  localparam int SEG_W        = 16;
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int FRAC_OUT_W   = FRAC_W + 1;
  localparam int AXES         = 3;
  localparam int AXIS_W       = 2;
  localparam int MUL_W        = (COORD_W > FRAC_W) ? COORD_W + 2 : FRAC_W + 2;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int ACC_W        = PROD_W + 2;
  localparam int DIST_W       = 48;
  localparam int WIDE_W       = (ACC_W > DIST_W) ? ACC_W : DIST_W;
  localparam int DIV_CNT_W    = $clog2(FRAC_W);

  localparam logic [DIST_W-1:0]     DIST_MAX   = {DIST_W{1'b1}};
  localparam logic [FRAC_OUT_W-1:0] FRAC_ONE   = {1'b1, {FRAC_W{1'b0}}};
  localparam logic [PROD_W:0]       ROUND_HALF = (PROD_W + 1)'(1) << (FRAC_W - 1);
  localparam logic [AXIS_W-1:0]     AXIS_LAST  = AXIS_W'(AXES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOT,
    ST_CHECK,
    ST_DIVIDE,
    ST_OFFSET,
    ST_SQUARE,
    ST_UPDATE,
    ST_FINISH
  } csp_state_t;

endpackage

>>> rtl/csp_vertex_if.sv
// ----------------------------------------------------------------------------
// csp_vertex_if: vertex input channel
// Valid/ready channel carrying one polyline vertex and the query point.
// ----------------------------------------------------------------------------
interface csp_vertex_if;
  import csp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] query_x;
  logic signed [COORD_W-1:0] query_y;
  logic signed [COORD_W-1:0] query_z;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic signed [COORD_W-1:0] vertex_z;
  logic                      first_vertex;
  logic                      last_vertex;

  modport source (
    output valid, query_x, query_y, query_z, vertex_x, vertex_y, vertex_z,
           first_vertex, last_vertex,
    input  ready
  );

  modport sink (
    input  valid, query_x, query_y, query_z, vertex_x, vertex_y, vertex_z,
           first_vertex, last_vertex,
    output ready
  );

endinterface

>>> rtl/csp_result_if.sv
// ----------------------------------------------------------------------------
// csp_result_if: result output channel
// Valid/ready channel carrying the nearest segment and its fraction.
// ----------------------------------------------------------------------------
interface csp_result_if;
  import csp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [SEG_W-1:0]      segment_index;
  logic [FRAC_OUT_W-1:0] fraction;
  logic                  found;

  modport source (
    output valid, segment_index, fraction, found,
    input  ready
  );

  modport sink (
    input  valid, segment_index, fraction, found,
    output ready
  );

endinterface

>>> rtl/csp_divider.sv
// ----------------------------------------------------------------------------
// csp_divider: radix-2 restoring fraction divider
// Forms floor(dividend * 2^FRAC_W / divisor) for dividend < divisor, one
// quotient bit per cycle; done pulses when the quotient is complete.
// ----------------------------------------------------------------------------
module csp_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [csp_pkg::ACC_W-1:0]  dividend,
  input  logic [csp_pkg::ACC_W-1:0]  divisor,
  output logic                       done,
  output logic [csp_pkg::FRAC_W-1:0] quotient
);
  import csp_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [ACC_W:0]       rem;
  logic [ACC_W-1:0]     dsr;
  logic [FRAC_W-1:0]    quo;
  logic [ACC_W:0]       shifted;
  logic [ACC_W+1:0]     diff;
  logic                 take;
  logic [ACC_W:0]       rem_next;

  always_comb begin
    shifted  = {rem[ACC_W-1:0], 1'b0};
    diff     = (ACC_W + 2)'(shifted) - (ACC_W + 2)'(dsr);
    take     = !diff[ACC_W+1];
    rem_next = take ? diff[ACC_W:0] : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + DIV_CNT_W'(1);
        if (count == DIV_CNT_W'(FRAC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, dividend};
      dsr <= divisor;
      quo <= '0;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[FRAC_W-2:0], take};
    end
  end

  assign quotient = quo;

endmodule

>>> rtl/closest_segment_on_polyline_unit.sv
// ----------------------------------------------------------------------------
// closest_segment_on_polyline_unit: nearest polyline segment to a point
// Streams polyline vertices, finds the segment nearest the query point and
// reports its index and clamped Q1.16 position on the last vertex.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Beat contents
//   vtx      in   query point, vertex, first_vertex, last_vertex
//   res      out  segment_index, fraction, found (one beat per path)
//
// A vertex that closes a segment forms six products for the two dot
// products and three each for the offset and the squared distance on one
// shared 18x18 multiplier, plus a quotient from the bit-serial divider.
// When t clamps to 0 or 1 the divider is skipped; a vertex that closes no
// segment goes from idle straight to the finish state. vtx is ready only
// while the unit is idle. A last vertex waits in the finish state while an
// earlier result beat has not been taken. Reset is synchronous and clears the search.
//
module closest_segment_on_polyline_unit (
  input logic         clk,
  input logic         rst,
  csp_vertex_if.sink  vtx,
  csp_result_if.source res
);
  import csp_pkg::*;

  csp_state_t state;
  csp_state_t state_next;

  logic signed [COORD_W-1:0] qpt  [AXES];
  logic signed [COORD_W-1:0] prev [AXES];
  logic signed [COORD_W-1:0] cur  [AXES];
  logic signed [MUL_W-1:0]   dvec [AXES];
  logic                      last_flag;

  logic                    have_previous;
  logic [CNT_W-1:0]        seg_count;
  logic [DIST_W-1:0]       best_dist;
  logic [SEG_W-1:0]        best_seg;
  logic [FRAC_OUT_W-1:0]   best_frac;
  logic                    any_segment;

  logic [AXIS_W-1:0]       axis;
  logic                    den_pass;
  logic signed [ACC_W-1:0] acc_num;
  logic signed [ACC_W-1:0] acc_den;
  logic [ACC_W-1:0]        acc_dist;
  logic [FRAC_OUT_W-1:0]   frac;

  logic                    out_valid;
  logic [SEG_W-1:0]        out_seg;
  logic [FRAC_OUT_W-1:0]   out_frac;
  logic                    out_found;

  logic                    accept;
  logic                    eval_go;
  logic                    div_start;
  logic                    div_done;
  logic [FRAC_W-1:0]       div_quotient;
  logic                    frac_zero;
  logic                    frac_one;
  logic                    can_leave;
  logic                    emit;
  logic                    take_best;

  logic signed [MUL_W-1:0]  bdiff;
  logic signed [MUL_W-1:0]  apdiff;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W:0]   rnd;
  logic signed [PROD_W:0]   off_full;
  logic signed [PROD_W:0]   d_full;
  logic [WIDE_W-1:0]        dist_wide;
  logic [DIST_W-1:0]        seg_dist;

  // Shared datapath.
  always_comb begin
    bdiff  = MUL_W'(cur[axis]) - MUL_W'(prev[axis]);
    apdiff = MUL_W'(qpt[axis]) - MUL_W'(prev[axis]);
    unique case (state)
      ST_DOT: begin
        mul_a = den_pass ? bdiff : apdiff;
        mul_b = bdiff;
      end
      ST_OFFSET: begin
        mul_a = $signed(MUL_W'(frac));
        mul_b = bdiff;
      end
      ST_SQUARE: begin
        mul_a = dvec[axis];
        mul_b = dvec[axis];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod     = mul_a * mul_b;
    rnd      = $signed({prod[PROD_W-1], prod}) + $signed(ROUND_HALF);
    off_full = rnd >>> FRAC_W;
    d_full   = off_full + (PROD_W + 1)'(prev[axis]) - (PROD_W + 1)'(qpt[axis]);
    dist_wide = WIDE_W'(acc_dist);
    seg_dist = (dist_wide > WIDE_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(dist_wide);
    frac_zero = (acc_den == '0) || acc_num[ACC_W-1] || (acc_num == '0);
    frac_one  = (acc_num >= acc_den);
    take_best = !any_segment || (seg_dist < best_dist);
  end

  csp_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_num),
    .divisor  (acc_den),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (vtx.valid) begin
          state_next = eval_go ? ST_DOT : ST_FINISH;
        end
      end
      ST_DOT: begin
        if (den_pass && axis == AXIS_LAST) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = (frac_zero || frac_one) ? ST_OFFSET : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_OFFSET;
        end
      end
      ST_OFFSET: begin
        if (axis == AXIS_LAST) begin
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (axis == AXIS_LAST) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (can_leave) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    eval_go   = !vtx.first_vertex && have_previous &&
                (seg_count < CNT_W'(MAX_SEGMENTS));
    accept    = (state == ST_IDLE) && vtx.valid;
    div_start = (state == ST_CHECK) && !frac_zero && !frac_one;
    can_leave = !last_flag || !out_valid || res.ready;
    emit      = (state == ST_FINISH) && last_flag && can_leave;
  end

  assign vtx.ready = (state == ST_IDLE);

  // Search state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        qpt[i] <= '0;
      end
      have_previous <= 1'b0;
      seg_count     <= '0;
      best_dist     <= DIST_MAX;
      best_seg      <= '0;
      best_frac     <= '0;
      any_segment   <= 1'b0;
    end else if (accept && vtx.first_vertex) begin
      qpt[0]        <= vtx.query_x;
      qpt[1]        <= vtx.query_y;
      qpt[2]        <= vtx.query_z;
      have_previous <= 1'b0;
      seg_count     <= '0;
      best_dist     <= DIST_MAX;
      best_seg      <= '0;
      best_frac     <= '0;
      any_segment   <= 1'b0;
    end else if (state == ST_UPDATE) begin
      seg_count <= seg_count + CNT_W'(1);
      if (take_best) begin
        best_dist   <= seg_dist;
        best_seg    <= seg_count[SEG_W-1:0];
        best_frac   <= frac;
        any_segment <= 1'b1;
      end
    end else if (state == ST_FINISH && can_leave) begin
      have_previous <= !last_flag;
      if (last_flag) begin
        seg_count   <= '0;
        best_dist   <= DIST_MAX;
        best_seg    <= '0;
        best_frac   <= '0;
        any_segment <= 1'b0;
      end
    end
  end

  // Step counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      axis     <= '0;
      den_pass <= 1'b0;
    end else begin
      if (state == ST_DOT || state == ST_OFFSET || state == ST_SQUARE) begin
        axis <= (axis == AXIS_LAST) ? '0 : axis + AXIS_W'(1);
      end else begin
        axis <= '0;
      end
      if (state == ST_DOT && axis == AXIS_LAST) begin
        den_pass <= 1'b1;
      end else if (state == ST_IDLE) begin
        den_pass <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur[0]    <= vtx.vertex_x;
      cur[1]    <= vtx.vertex_y;
      cur[2]    <= vtx.vertex_z;
      last_flag <= vtx.last_vertex;
      acc_num   <= '0;
      acc_den   <= '0;
      acc_dist  <= '0;
    end
    if (state == ST_DOT) begin
      if (den_pass) begin
        acc_den <= acc_den + ACC_W'(prod);
      end else begin
        acc_num <= acc_num + ACC_W'(prod);
      end
    end
    if (state == ST_CHECK) begin
      frac <= frac_zero ? '0 : FRAC_ONE;
    end
    if (state == ST_DIVIDE && div_done) begin
      frac <= FRAC_OUT_W'(div_quotient);
    end
    if (state == ST_OFFSET) begin
      dvec[axis] <= d_full[MUL_W-1:0];
    end
    if (state == ST_SQUARE) begin
      acc_dist <= acc_dist + ACC_W'(prod);
    end
    if (state == ST_FINISH && can_leave) begin
      for (int i = 0; i < AXES; i++) begin
        prev[i] <= cur[i];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_seg   <= any_segment ? best_seg : '0;
      out_frac  <= any_segment ? best_frac : '0;
      out_found <= any_segment;
    end
  end

  assign res.valid         = out_valid;
  assign res.segment_index = out_seg;
  assign res.fraction      = out_frac;
  assign res.found         = out_found;

endmodule
